FILE: sv/rgb2hsv_pkg.sv
// rgb2hsv_pkg: widths, payload structs and stage types of the RGB to HSV converter.
// Depends on nothing. Used by rgb2hsv_div_pipe and rgb_to_hsv_converter_core.
`default_nettype none

package rgb2hsv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 12;

  // Remainder / divisor width of the hue divider: 6*d < 2^(CHANNEL_BITS+3)
  localparam int HREM_W = CHANNEL_BITS + 3;
  // Signed hue numerator before the absolute value
  localparam int NUM_W  = CHANNEL_BITS + 4;
  // One divider stage per quotient bit of the longer division
  localparam int NSTG   = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
  localparam int HUE_FIRST = NSTG - HUE_BITS;
  localparam int SAT_FIRST = NSTG - CHANNEL_BITS;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } pixel_out_t;

  // Which channel is the maximum, and how the hue offset is built
  typedef enum logic [1:0] {
    SEC_RED_G = 2'd0,  // red max, green >= blue: offset 0
    SEC_RED_B = 2'd1,  // red max, blue > green: offset -1 turn
    SEC_GREEN = 2'd2,  // green max: offset -1/3 turn
    SEC_BLUE  = 2'd3   // blue max: offset +2/3 turn
  } sector_t;

  // Operands handed from the front end to the divider pipe
  typedef struct packed {
    logic [HREM_W-1:0]         mag;     // |hue numerator|, < d6
    logic [HREM_W-1:0]         d6;      // 6*d
    logic [2*CHANNEL_BITS-1:0] sat_num; // d * max code
    logic [CHANNEL_BITS-1:0]   qx;      // max channel
    logic                      grey;    // d == 0
    logic                      black;   // qx == 0
  } div_op_t;

  // State carried through one divider stage
  typedef struct packed {
    logic [HREM_W-1:0]       hrem;
    logic [HUE_BITS-1:0]     hq;
    logic [HREM_W-1:0]       d6;
    logic [CHANNEL_BITS-1:0] srem;
    logic [CHANNEL_BITS-1:0] sq;
    logic [CHANNEL_BITS-1:0] nlo;
    logic [CHANNEL_BITS-1:0] qx;
    logic                    grey;
    logic                    black;
  } div_stage_t;

endpackage

`default_nettype wire

FILE: sv/rgb_to_hsv_converter_core.sv
// rgb_to_hsv_converter_core: top level, RGB pixel in, hue / saturation / value out.
// Depends on rgb2hsv_pkg and rgb2hsv_div_pipe.
//
//   channel  ports                      direction  transfer when
//   input    start, busy, in_pixel      in         start && !busy at clk rise
//   result   out_valid, out_hsv         out        out_valid high for one cycle
//
// One pixel per clock, every clock: three front-end stages, then one stage
// per quotient bit of the longer of the two dividers (hue, 12 bits), which
// sets the depth. busy is always low; the pipeline never stalls and the
// receiver cannot stall.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

module rgb_to_hsv_converter_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire rgb2hsv_pkg::pixel_in_t   in_pixel,
  output      logic                    out_valid,
  output      rgb2hsv_pkg::pixel_out_t  out_hsv
);

  localparam int CB = rgb2hsv_pkg::CHANNEL_BITS;
  localparam int NW = rgb2hsv_pkg::NUM_W;
  localparam int HW = rgb2hsv_pkg::HREM_W;

  // ---- stage 1: channel ordering ------------------------------------------
  logic                 v1_r;
  rgb2hsv_pkg::sector_t sec1_r, sec1_nxt;
  logic [CB-1:0]        qx1_r, qx1_nxt;
  logic [CB-1:0]        qw1_r, qw1_nxt;
  logic [CB-1:0]        py1_r, py1_nxt;
  logic                 sel1, sel2;
  logic [CB-1:0]        px;

  // ---- stage 2: spread and channel difference -----------------------------
  logic                 v2_r;
  rgb2hsv_pkg::sector_t sec2_r;
  logic [CB-1:0]        qx2_r;
  logic [CB-1:0]        d2_r, d2_nxt;
  logic signed [CB:0]   diff2_r, diff2_nxt;
  logic [CB-1:0]        lo;

  // ---- stage 3: hue numerator, 6d, saturation numerator -------------------
  logic                 v3_r;
  rgb2hsv_pkg::div_op_t op3_r, op3_nxt;
  logic signed [NW-1:0] dw, d6w, diffw, offw, numw, magw;

  assign busy = 1'b0;

  // Two compare-selects; ties go to green over blue, and to red over either
  always_comb begin
    sel1    = (in_pixel.green >= in_pixel.blue);
    px      = sel1 ? in_pixel.green : in_pixel.blue;
    py1_nxt = sel1 ? in_pixel.blue  : in_pixel.green;
    sel2    = (in_pixel.red >= px);
    qx1_nxt = sel2 ? in_pixel.red : px;
    qw1_nxt = sel2 ? px : in_pixel.red;
    if (sel2) begin
      sec1_nxt = sel1 ? rgb2hsv_pkg::SEC_RED_G : rgb2hsv_pkg::SEC_RED_B;
    end else begin
      sec1_nxt = sel1 ? rgb2hsv_pkg::SEC_GREEN : rgb2hsv_pkg::SEC_BLUE;
    end
  end

  always_comb begin
    lo        = (qw1_r < py1_r) ? qw1_r : py1_r;
    d2_nxt    = qx1_r - lo;
    diff2_nxt = $signed({1'b0, qw1_r}) - $signed({1'b0, py1_r});
  end

  // Hue numerator = offset*6d + (qw - py); its magnitude is always below 6d,
  // so the hue quotient fits HUE_BITS without clamping.
  always_comb begin
    dw    = $signed(NW'(d2_r));
    d6w   = (dw <<< 2) + (dw <<< 1);
    diffw = $signed({{(NW-CB-1){diff2_r[CB]}}, diff2_r});
    case (sec2_r)
      rgb2hsv_pkg::SEC_RED_G: offw = '0;
      rgb2hsv_pkg::SEC_RED_B: offw = -d6w;
      rgb2hsv_pkg::SEC_GREEN: offw = -(dw <<< 1);
      rgb2hsv_pkg::SEC_BLUE:  offw = dw <<< 2;
      default:                offw = '0;
    endcase
    numw = offw + diffw;
    magw = (numw < 0) ? -numw : numw;

    op3_nxt.mag     = magw[HW-1:0];
    op3_nxt.d6      = d6w[HW-1:0];
    op3_nxt.sat_num = {d2_r, {CB{1'b0}}} - {{CB{1'b0}}, d2_r};
    op3_nxt.qx      = qx2_r;
    op3_nxt.grey    = (d2_r == '0);
    op3_nxt.black   = (qx2_r == '0);
  end

  always_ff @(posedge clk) begin
    sec1_r  <= sec1_nxt;
    qx1_r   <= qx1_nxt;
    qw1_r   <= qw1_nxt;
    py1_r   <= py1_nxt;
    sec2_r  <= sec1_r;
    qx2_r   <= qx1_r;
    d2_r    <= d2_nxt;
    diff2_r <= diff2_nxt;
    op3_r   <= op3_nxt;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Hue and saturation dividers, one quotient bit per stage
  rgb2hsv_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_op     (op3_r),
    .out_valid (out_valid),
    .out_res   (out_hsv)
  );

endmodule

`default_nettype wire

FILE: sv/rgb2hsv_div_pipe.sv
// rgb2hsv_div_pipe: pipelined restoring dividers for hue and saturation, one bit per stage.
// Depends on rgb2hsv_pkg.
`default_nettype none

module rgb2hsv_div_pipe (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire rgb2hsv_pkg::div_op_t    in_op,
  output      logic                   out_valid,
  output      rgb2hsv_pkg::pixel_out_t out_res
);

  localparam int CB = rgb2hsv_pkg::CHANNEL_BITS;
  localparam int HW = rgb2hsv_pkg::HREM_W;
  localparam int NS = rgb2hsv_pkg::NSTG;

  rgb2hsv_pkg::div_stage_t stg_d [0:NS-1];
  rgb2hsv_pkg::div_stage_t st_r  [0:NS-1];
  logic                    vld_d [0:NS-1];
  logic                    vld_r [0:NS-1];
  rgb2hsv_pkg::div_stage_t init_stg;

  // Hue remainder starts at mag (< d6); saturation remainder at the upper half of d*max,
  // which is below qx, so both quotients come out one bit per step.
  always_comb begin
    init_stg.hrem  = in_op.mag;
    init_stg.hq    = '0;
    init_stg.d6    = in_op.d6;
    init_stg.srem  = in_op.sat_num[2*CB-1:CB];
    init_stg.sq    = '0;
    init_stg.nlo   = in_op.sat_num[CB-1:0];
    init_stg.qx    = in_op.qx;
    init_stg.grey  = in_op.grey;
    init_stg.black = in_op.black;
  end

  assign stg_d[0] = init_stg;
  assign vld_d[0] = in_valid;

  for (genvar k = 0; k < NS; k++) begin : g_stg
    rgb2hsv_pkg::div_stage_t st_nxt;
    logic [HW:0]             hr2;
    logic [CB:0]             sr2;

    if (k > 0) begin : g_link
      assign stg_d[k] = st_r[k-1];
      assign vld_d[k] = vld_r[k-1];
    end

    always_comb begin
      st_nxt = stg_d[k];
      hr2    = {stg_d[k].hrem, 1'b0};
      sr2    = {stg_d[k].srem, stg_d[k].nlo[CB-1]};
      if (k >= rgb2hsv_pkg::HUE_FIRST) begin
        if (hr2 >= {1'b0, stg_d[k].d6}) begin
          st_nxt.hrem = HW'(hr2 - {1'b0, stg_d[k].d6});
          st_nxt.hq   = {stg_d[k].hq[rgb2hsv_pkg::HUE_BITS-2:0], 1'b1};
        end else begin
          st_nxt.hrem = hr2[HW-1:0];
          st_nxt.hq   = {stg_d[k].hq[rgb2hsv_pkg::HUE_BITS-2:0], 1'b0};
        end
      end
      if (k >= rgb2hsv_pkg::SAT_FIRST) begin
        st_nxt.nlo = {stg_d[k].nlo[CB-2:0], 1'b0};
        if (sr2 >= {1'b0, stg_d[k].qx}) begin
          st_nxt.srem = CB'(sr2 - {1'b0, stg_d[k].qx});
          st_nxt.sq   = {stg_d[k].sq[CB-2:0], 1'b1};
        end else begin
          st_nxt.srem = sr2[CB-1:0];
          st_nxt.sq   = {stg_d[k].sq[CB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_d[k];
      end
    end
  end

  // Grey pixel: hue 0. Black pixel: saturation 0.
  assign out_valid          = vld_r[NS-1];
  assign out_res.hue        = st_r[NS-1].grey  ? '0 : st_r[NS-1].hq;
  assign out_res.saturation = st_r[NS-1].black ? '0 : st_r[NS-1].sq;
  assign out_res.brightness = st_r[NS-1].qx;

endmodule

`default_nettype wire
